// ===== src/xkd_pkg.sv =====
`default_nettype none
package xkd_pkg;

  // Result field widths and saturation limits
  localparam int unsigned ScoreW = 17;
  localparam int unsigned SumW   = 19;
  localparam int unsigned PtsW   = 6;
  localparam logic [ScoreW-1:0] ScoreMax = '1;
  localparam logic [SumW-1:0]   SumMax   = '1;

  // Configuration port geometry and register indexes
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  typedef enum logic [1:0] {
    REG_KEY_FIRST  = 2'd0,
    REG_KEY_SECOND = 2'd1,
    REG_KEY_THIRD  = 2'd2,
    REG_NONE       = 2'd3
  } reg_e;

  // Key byte rotation
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  // Classified word handed from front to back
  typedef struct packed {
    logic [7:0]      plain;
    logic [PtsW-1:0] pts;
    logic            bad;
    logic            last;
  } entry_t;

endpackage
`default_nettype wire

// ===== src/xor_key_decrypt_and_score.sv =====
// Repeating-key XOR decryptor with an English-likeness score.
// Input channel (in_valid_i/in_ready_o): one ciphertext word per transfer,
// cipher_byte_i plus last_byte_i marking the final word of a message.
// Output channel (out_valid_o/out_ready_i): one result per message, carrying
// text_valid_o, text_score_o and byte_sum_o; score and sum read zero when any
// decrypted word was neither printable nor a newline.
// Throughput: one word per cycle while the queue has room. The front decrypts and
// classifies a word in the cycle it is accepted and writes it into a two-entry
// queue; the back accumulates one queued word per cycle into the saturating
// totals unless a final word waits on a held result. out_valid_o is registered
// and is set when the back pops the final word, after any older queued words.
// Keys are set over the APB port at byte addresses 0, 4 and 8 while idle.
// Reset sets all three keys to 'a' (0x61) and clears the message state.
// When the receiver stalls, the result stays in the output register; the
// back keeps absorbing words of the next message until it reaches that
// message's final word, then the queue fills and in_ready_o drops.
`default_nettype none
module xor_key_decrypt_and_score #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xkd_pkg::AddrW-1:0]   paddr,
  input  logic [xkd_pkg::DataW-1:0]   pwdata,
  output logic [xkd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  cipher_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        text_valid_o,
  output logic [xkd_pkg::ScoreW-1:0]  text_score_o,
  output logic [xkd_pkg::SumW-1:0]    byte_sum_o
);
  import xkd_pkg::*;

  localparam logic [7:0] KeyReset = 8'h61;

  logic [7:0] key_first_q, key_second_q, key_third_q;
  reg_e       reg_sel;
  logic       wr_en;
  logic       push, pop, full, empty;
  entry_t     front_entry, back_entry;

  // Register access
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= KeyReset;
      key_second_q <= KeyReset;
      key_third_q  <= KeyReset;
    end else if (wr_en) begin
      case (reg_sel)
        REG_KEY_FIRST:  key_first_q  <= pwdata[7:0];
        REG_KEY_SECOND: key_second_q <= pwdata[7:0];
        REG_KEY_THIRD:  key_third_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_FIRST:  prdata = {(DataW - 8)'(0), key_first_q};
      REG_KEY_SECOND: prdata = {(DataW - 8)'(0), key_second_q};
      REG_KEY_THIRD:  prdata = {(DataW - 8)'(0), key_third_q};
      default:        prdata = '0;
    endcase
  end

  xkd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_first_i   (key_first_q),
    .key_second_i  (key_second_q),
    .key_third_i   (key_third_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cipher_byte_i (cipher_byte_i),
    .last_byte_i   (last_byte_i),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  xkd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (back_entry)
  );

  xkd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (back_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .text_valid_o (text_valid_o),
    .text_score_o (text_score_o),
    .byte_sum_o   (byte_sum_o)
  );

endmodule
`default_nettype wire

// ===== src/xkd_front.sv =====
`default_nettype none
module xkd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        key_first_i,
  input  logic [7:0]        key_second_i,
  input  logic [7:0]        key_third_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        cipher_byte_i,
  input  logic              last_byte_i,
  input  logic              full_i,
  output logic              push_o,
  output xkd_pkg::entry_t   entry_o
);
  import xkd_pkg::*;

  localparam logic [7:0] ChSp = 8'h20;
  localparam logic [7:0] ChNl = 8'h0A;
  localparam logic [7:0] ChTl = 8'h7E;

  // Per-byte letter points, case-insensitive
  function automatic logic [2:0] letter_points(input logic [7:0] p);
    logic [7:0] c;
    c = (p >= "A" && p <= "Z") ? (p + 8'd32) : p;
    case (c)
      ChSp: letter_points = 3'd6;
      "e", "t", "a", "o", "i", "n", "s", "h", "r", "d", "l", "u":
        letter_points = 3'd3;
      default: letter_points = (c >= "a" && c <= "z") ? 3'd1 : 3'd0;
    endcase
  endfunction

  // Word matches ending on the current byte, w0 oldest
  function automatic logic [PtsW-1:0] word_points(input logic [7:0] w0, input logic [7:0] w1,
                                                 input logic [7:0] w2, input logic [7:0] w3,
                                                 input logic [7:0] w4);
    logic [PtsW-1:0] pts;
    pts = '0;
    if (w0 == ChSp && w4 == ChSp) begin
      if (w1 == "t" && w2 == "h" && w3 == "e") pts = pts + PtsW'(40);
      if (w1 == "a" && w2 == "n" && w3 == "d") pts = pts + PtsW'(25);
    end
    if (w1 == ChSp && w4 == ChSp) begin
      if (w2 == "o" && w3 == "f") pts = pts + PtsW'(20);
      if (w2 == "t" && w3 == "o") pts = pts + PtsW'(20);
      if (w2 == "i" && w3 == "n") pts = pts + PtsW'(15);
    end
    word_points = pts;
  endfunction

  phase_e     phase_q, phase_d, phase_nx;
  logic [7:0] hist_q [4];
  logic [7:0] key;
  logic [7:0] plain;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // Pick the key byte for this position
  always_comb begin
    case (phase_q)
      PH_SECOND: begin
        key      = key_second_i;
        phase_nx = PH_THIRD;
      end
      PH_THIRD: begin
        key      = key_third_i;
        phase_nx = PH_FIRST;
      end
      default: begin
        key      = key_first_i;
        phase_nx = PH_SECOND;
      end
    endcase
    phase_d = phase_q;
    if (push_o) begin
      phase_d = last_byte_i ? PH_FIRST : phase_nx;
    end
  end

  // Decrypt and classify
  assign plain         = cipher_byte_i ^ key;
  assign entry_o.plain = plain;
  assign entry_o.bad   = !(plain == ChNl || (plain >= ChSp && plain <= ChTl));
  assign entry_o.last  = last_byte_i;
  assign entry_o.pts   = PtsW'(letter_points(plain))
                       + word_points(hist_q[0], hist_q[1], hist_q[2], hist_q[3], plain);

  // Advance phase and history; drop history at message end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      for (int i = 0; i < 4; i++) hist_q[i] <= '0;
    end else begin
      phase_q <= phase_d;
      if (push_o) begin
        if (last_byte_i) begin
          for (int i = 0; i < 4; i++) hist_q[i] <= '0;
        end else begin
          hist_q[0] <= hist_q[1];
          hist_q[1] <= hist_q[2];
          hist_q[2] <= hist_q[3];
          hist_q[3] <= plain;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/xkd_queue.sv =====
`default_nettype none
module xkd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xkd_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output xkd_pkg::entry_t rdata_o
);
  import xkd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/xkd_back.sv =====
`default_nettype none
module xkd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  xkd_pkg::entry_t             entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        text_valid_o,
  output logic [xkd_pkg::ScoreW-1:0]  text_score_o,
  output logic [xkd_pkg::SumW-1:0]    byte_sum_o
);
  import xkd_pkg::*;

  logic              bad_q;
  logic [ScoreW-1:0] score_q;
  logic [SumW-1:0]   sum_q;
  logic [ScoreW:0]   score_add;
  logic [SumW:0]     sum_add;
  logic [ScoreW-1:0] score_sat;
  logic [SumW-1:0]   sum_sat;
  logic              bad_all;
  logic              ovalid_q;
  logic              tvalid_q;
  logic [ScoreW-1:0] tscore_q;
  logic [SumW-1:0]   bsum_q;

  // Take a word unless it ends a message and the result slot is still held
  assign pop_o = !empty_i && (!entry_i.last || !ovalid_q || out_ready_i);

  // Saturating accumulate
  assign score_add = {1'b0, score_q} + (ScoreW + 1)'(entry_i.pts);
  assign sum_add   = {1'b0, sum_q} + (SumW + 1)'(entry_i.plain);
  assign score_sat = (score_add > {1'b0, ScoreMax}) ? ScoreMax : score_add[ScoreW-1:0];
  assign sum_sat   = (sum_add > {1'b0, SumMax}) ? SumMax : sum_add[SumW-1:0];
  assign bad_all   = bad_q || entry_i.bad;

  // Message accumulators; clear at message end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q   <= 1'b0;
      score_q <= '0;
      sum_q   <= '0;
    end else if (pop_o) begin
      if (entry_i.last) begin
        bad_q   <= 1'b0;
        score_q <= '0;
        sum_q   <= '0;
      end else begin
        bad_q   <= bad_all;
        score_q <= score_sat;
        sum_q   <= sum_sat;
      end
    end
  end

  // Result register; hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (pop_o && entry_i.last) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.last) begin
      tvalid_q <= !bad_all;
      tscore_q <= bad_all ? '0 : score_sat;
      bsum_q   <= bad_all ? '0 : sum_sat;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign text_valid_o = tvalid_q;
  assign text_score_o = tscore_q;
  assign byte_sum_o   = bsum_q;

endmodule
`default_nettype wire

// ===== src/xkd_checker.sv =====
`default_nettype none
module xkd_checker (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [xkd_pkg::AddrW-1:0]   paddr,
  input  wire [xkd_pkg::DataW-1:0]   pwdata,
  input  wire [xkd_pkg::DataW-1:0]   prdata,
  input  wire                        pready,
  input  wire                        in_valid_i,
  input  wire                        in_ready_o,
  input  wire                        out_valid_o,
  input  wire                        out_ready_i,
  input  wire                        text_valid_o,
  input  wire [xkd_pkg::ScoreW-1:0]  text_score_o,
  input  wire [xkd_pkg::SumW-1:0]    byte_sum_o
);

  // Stalled result holds its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(text_valid_o)
      && $stable(text_score_o) && $stable(byte_sum_o))
    else $error("result changed while stalled");

  // Rejected text reports zero score and sum
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !text_valid_o |-> text_score_o == '0 && byte_sum_o == '0)
    else $error("nonzero totals on rejected text");

  // Accepted text holds at least one printable or newline word
  a_good_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_valid_o |-> byte_sum_o >= 19'd10)
    else $error("valid text with too small a sum");

  // Written first key reads back on the next cycle
  a_key_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == '0 |=> paddr != '0
      || prdata[7:0] == $past(pwdata[7:0]))
    else $error("key register read back mismatch");

  // Input ready never drops without words pending
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input ready dropped with no word taken");

endmodule

bind xor_key_decrypt_and_score xkd_checker u_xkd_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import xkd_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned HOLD_AFTER    = 30;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned PHASE_WORDS   = 180;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned LONG_REPEATS  = 100;
  localparam int unsigned NUM_DIR       = 27;
  localparam string COMMON_LETTERS      = "etaoinshrdlu";

  // One message verdict as the block reports it
  typedef struct packed {
    logic              valid;
    logic [ScoreW-1:0] score;
    logic [SumW-1:0]   total;
  } verdict_t;

  // One directed word, given as plaintext under the reset keys
  typedef struct packed {
    logic [7:0] plain;
    logic       last;
    logic       typed;
    verdict_t   want;
  } dir_row_t;

  typedef enum int {
    MSG_ENGLISH,
    MSG_NOISE,
    MSG_BROKEN,
    MSG_PRINTABLE
  } msg_kind_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        cipher_byte_i = '0;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              text_valid_o;
  logic [ScoreW-1:0] text_score_o;
  logic [SumW-1:0]   byte_sum_o;

  xor_key_decrypt_and_score dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cipher_byte_i(cipher_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .text_valid_o (text_valid_o),
    .text_score_o (text_score_o),
    .byte_sum_o   (byte_sum_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Scorer copy: keys, rotation and per-message totals
  logic [7:0]        key_bank [3] = '{8'h61, 8'h61, 8'h61};
  phase_e            phase_m = PH_FIRST;
  bit                tainted = 1'b0;
  logic [ScoreW-1:0] score_acc = '0;
  logic [SumW-1:0]   sum_acc = '0;
  logic [7:0]        hist_m [4] = '{8'h00, 8'h00, 8'h00, 8'h00};

  verdict_t   verdict_q [$];
  logic [7:0] text_q [$];
  bit         idle_on = 1'b1;
  bit         hold_done = 1'b0;
  int         mismatch_count = 0;
  int         result_count = 0;
  int         word_count = 0;
  int         msg_count = 0;
  int         key_writes = 0;

  string vocab [14] = '{"the", "and", "of", "to", "in", "The", "AND", "a", "zebra",
                        "quiz", "key", "hello", "x", "Of"};

  dir_row_t dir_rows [NUM_DIR] = '{
    // single-word messages: invalid, extremes of the printable range, letters
    '{8'h00, 1'b1, 1'b1, '{1'b0, 17'd0, 19'd0}},
    '{8'h9E, 1'b1, 1'b1, '{1'b0, 17'd0, 19'd0}},
    '{8'h20, 1'b1, 1'b1, '{1'b1, 17'd6, 19'd32}},
    '{8'h0A, 1'b1, 1'b1, '{1'b1, 17'd0, 19'd10}},
    '{8'h7E, 1'b1, 1'b1, '{1'b1, 17'd0, 19'd126}},
    '{8'h7F, 1'b1, 1'b1, '{1'b0, 17'd0, 19'd0}},
    '{8'h45, 1'b1, 1'b1, '{1'b1, 17'd3, 19'd69}},
    '{8'h7A, 1'b1, 1'b1, '{1'b1, 17'd1, 19'd122}},
    // " the and " with overlapping word matches
    '{8'h20, 1'b0, 1'b0, '0}, '{8'h74, 1'b0, 1'b0, '0}, '{8'h68, 1'b0, 1'b0, '0},
    '{8'h65, 1'b0, 1'b0, '0}, '{8'h20, 1'b0, 1'b0, '0}, '{8'h61, 1'b0, 1'b0, '0},
    '{8'h6E, 1'b0, 1'b0, '0}, '{8'h64, 1'b0, 1'b0, '0}, '{8'h20, 1'b1, 1'b0, '0},
    // " of to in " with a match right after the zeroed history
    '{8'h20, 1'b0, 1'b0, '0}, '{8'h6F, 1'b0, 1'b0, '0}, '{8'h66, 1'b0, 1'b0, '0},
    '{8'h20, 1'b0, 1'b0, '0}, '{8'h74, 1'b0, 1'b0, '0}, '{8'h6F, 1'b0, 1'b0, '0},
    '{8'h20, 1'b0, 1'b0, '0}, '{8'h69, 1'b0, 1'b0, '0}, '{8'h6E, 1'b0, 1'b0, '0},
    '{8'h20, 1'b1, 1'b0, '0}
  };

  function automatic logic [7:0] next_key();
    case (phase_m)
      PH_SECOND: return key_bank[1];
      PH_THIRD:  return key_bank[2];
      default:   return key_bank[0];
    endcase
  endfunction

  function automatic void clear_message();
    phase_m   = PH_FIRST;
    tainted   = 1'b0;
    score_acc = '0;
    sum_acc   = '0;
    for (int i = 0; i < 4; i++) hist_m[i] = 8'h00;
  endfunction

  // Decrypt one word, fold it into the totals, return 1 with a verdict on the last word
  function automatic bit decrypt_score_word(input logic [7:0] cb, input logic lb,
                                            output verdict_t v);
    logic [7:0]  p;
    logic [7:0]  lc;
    int unsigned pts;
    int unsigned score_next;
    int unsigned sum_next;
    p = cb ^ next_key();
    case (phase_m)
      PH_SECOND: phase_m = PH_THIRD;
      PH_THIRD:  phase_m = PH_FIRST;
      default:   phase_m = PH_SECOND;
    endcase
    if (!(p == 8'h0A || (p >= 8'h20 && p <= 8'h7E))) tainted = 1'b1;

    // letter weight, case-insensitive
    lc  = (p >= "A" && p <= "Z") ? p + 8'd32 : p;
    pts = 0;
    if (lc == " ") begin
      pts = 6;
    end else if (lc >= "a" && lc <= "z") begin
      pts = 1;
      for (int i = 0; i < COMMON_LETTERS.len(); i++)
        if (lc == COMMON_LETTERS[i]) pts = 3;
    end

    // padded words ending on this byte, case-sensitive
    if (hist_m[0] == " " && p == " ") begin
      if (hist_m[1] == "t" && hist_m[2] == "h" && hist_m[3] == "e") pts += 40;
      if (hist_m[1] == "a" && hist_m[2] == "n" && hist_m[3] == "d") pts += 25;
    end
    if (hist_m[1] == " " && p == " ") begin
      if (hist_m[2] == "o" && hist_m[3] == "f") pts += 20;
      if (hist_m[2] == "t" && hist_m[3] == "o") pts += 20;
      if (hist_m[2] == "i" && hist_m[3] == "n") pts += 15;
    end

    // saturate on full-width sums
    score_next = score_acc + pts;
    sum_next   = sum_acc + p;
    score_acc  = (score_next > ScoreMax) ? ScoreMax : ScoreW'(score_next);
    sum_acc    = (sum_next > SumMax) ? SumMax : SumW'(sum_next);
    hist_m[0] = hist_m[1];
    hist_m[1] = hist_m[2];
    hist_m[2] = hist_m[3];
    hist_m[3] = p;

    v = '0;
    if (!lb) return 1'b0;
    if (!tainted) v = '{valid: 1'b1, score: score_acc, total: sum_acc};
    clear_message();
    return 1'b1;
  endfunction

  // Offer one word, hold it until taken, then queue its verdict if it closes a message
  task automatic send_word(input logic [7:0] cb, input logic lb, input logic typed,
                           input verdict_t want);
    verdict_t v;
    int       gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cipher_byte_i <= cb;
    last_byte_i   <= lb;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    word_count++;
    if (decrypt_score_word(cb, lb, v)) begin
      verdict_q.push_back(typed ? want : v);
      msg_count++;
    end
  endtask

  task automatic send_text(input bit raw);
    logic [7:0] cb;
    for (int i = 0; i < text_q.size(); i++) begin
      cb = raw ? text_q[i] : text_q[i] ^ next_key();
      send_word(cb, i == text_q.size() - 1, 1'b0, '0);
    end
  endtask

  // Stop offering, wait out every pending verdict and the pipeline tail
  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Two-phase register write, then the bus returns idle; random upper bits on the bus
  task automatic write_key(input reg_e idx, input logic [7:0] val);
    logic [DataW-1:0] bus_word;
    bus_word      = $urandom;
    bus_word[7:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= bus_word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_KEY_FIRST:  key_bank[0] = val;
      REG_KEY_SECOND: key_bank[1] = val;
      REG_KEY_THIRD:  key_bank[2] = val;
      default: ;
    endcase
    key_writes++;
  endtask

  task automatic load_keys(input logic [7:0] k0, input logic [7:0] k1,
                           input logic [7:0] k2);
    write_key(REG_KEY_FIRST, k0);
    write_key(REG_KEY_SECOND, k1);
    write_key(REG_KEY_THIRD, k2);
    // unmapped slot must leave the keys alone
    write_key(REG_NONE, 8'($urandom_range(0, 255)));
  endtask

  // Fill text_q with one plaintext (or raw ciphertext) message
  task automatic build_text(input int len, input msg_kind_e kind);
    string      w;
    logic [7:0] b;
    int         pos;
    text_q.delete();
    if (kind == MSG_NOISE) begin
      repeat (len) text_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == MSG_PRINTABLE) begin
      repeat (len)
        text_q.push_back(($urandom_range(0, 15) == 0) ? 8'h0A :
                         8'($urandom_range(32, 126)));
    end else begin
      if ($urandom_range(0, 1)) text_q.push_back(" ");
      while (text_q.size() < len) begin
        w = vocab[$urandom_range(0, $size(vocab) - 1)];
        for (int i = 0; i < w.len(); i++) text_q.push_back(w[i]);
        case ($urandom_range(0, 9))
          0:       text_q.push_back(8'h0A);
          1:       text_q.push_back(".");
          default: text_q.push_back(" ");
        endcase
      end
      while (text_q.size() > len) void'(text_q.pop_back());
      if (kind == MSG_BROKEN) begin
        b = 8'($urandom_range(0, 255));
        while (b == 8'h0A || (b >= 8'h20 && b <= 8'h7E)) b = 8'($urandom_range(0, 255));
        pos = $urandom_range(0, len - 1);
        text_q[pos] = b;
      end
    end
  endtask

  initial begin : stimulus
    int        phase_words;
    int        len;
    int        pick;
    msg_kind_e kind;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset keys
    for (int i = 0; i < NUM_DIR; i++)
      send_word(dir_rows[i].plain ^ next_key(), dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].want);
    drain();

    // One long message of back-to-back " the " matches
    load_keys(8'h00, 8'h00, 8'h00);
    text_q.delete();
    repeat (LONG_REPEATS) begin
      text_q.push_back(" ");
      text_q.push_back("t");
      text_q.push_back("h");
      text_q.push_back("e");
    end
    text_q.push_back(" ");
    send_text(1'b0);
    drain();

    // Random messages across several key settings, quiet in the last phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       load_keys(8'hFF, 8'hFF, 8'hFF);
        1:       load_keys(8'h00, 8'hFF, 8'h80);
        default: load_keys(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
      endcase
      idle_on     = (ph != NUM_PHASES - 1);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        pick = $urandom_range(0, 9);
        kind = (pick < 7) ? MSG_ENGLISH : (pick == 7) ? MSG_NOISE :
               (pick == 8) ? MSG_BROKEN : MSG_PRINTABLE;
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) :
               $urandom_range(1, 24);
        build_text(len, kind);
        send_text(kind == MSG_NOISE);
        phase_words += len;
      end
      drain();
    end

    $display("tb_top: %0d words in %0d messages, %0d verdicts checked, %0d register writes",
             word_count, msg_count, result_count, key_writes);
    $display("tb_top: covered invalid text, word matches, key changes and a %0d-cycle hold",
             LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  initial begin : sink
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && result_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each delivered verdict with the oldest pending one
  always @(posedge clk_i) begin : check_verdict
    verdict_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with none pending: text_valid %0d text_score %0d byte_sum %0d",
               text_valid_o, text_score_o, byte_sum_o);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (text_valid_o !== want.valid) begin
          $error("text_valid: expected %0d, got %0d", want.valid, text_valid_o);
          mismatch_count++;
        end
        if (text_score_o !== want.score) begin
          $error("text_score: expected %0d, got %0d", want.score, text_score_o);
          mismatch_count++;
        end
        if (byte_sum_o !== want.total) begin
          $error("byte_sum: expected %0d, got %0d", want.total, byte_sum_o);
          mismatch_count++;
        end
      end
      result_count++;
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
